// File: hw/rtl/hud_pkg.sv
// Package for the HCI UART packet deframer: header codes, packet kinds,
// parser state encoding and the result beat type. No dependencies.
`default_nettype none

package hud_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 17;

  localparam logic [ByteW-1:0] HdrEvent       = 8'h04;
  localparam logic [ByteW-1:0] HdrAcl         = 8'h02;
  localparam logic [ByteW-1:0] HdrVendor      = 8'h05;
  localparam logic [ByteW-1:0] VendorLenReset = 8'd10;
  localparam logic [ByteW-1:0] VendorLenMin   = 8'd2;

  localparam logic [CountW-1:0] EventLenPos = 17'd3;
  localparam logic [CountW-1:0] AclLowPos   = 17'd4;
  localparam logic [CountW-1:0] AclHighPos  = 17'd5;
  localparam logic [CountW-1:0] EventOvh    = 17'd3;
  localparam logic [CountW-1:0] AclOvh      = 17'd5;

  typedef enum logic [1:0] {
    KindEvent  = 2'd0,
    KindAcl    = 2'd1,
    KindVendor = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StEvent  = 4'b0010,
    StAcl    = 4'b0100,
    StVendor = 4'b1000
  } parse_state_e;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    kind_e             packet_kind;
    logic [CountW-1:0] byte_index;
    logic              packet_end;
    logic              dropped;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/hci_uart_packet_deframer.sv
// Top level of the HCI UART (H4) packet deframer: header parse, length
// tracking and a two-entry output stage. Depends on hud_pkg.
//
// channel | direction | handshake             | payload
// rx      | in        | rx_valid_i/rx_stall_o | rx_byte_i
// out     | out       | out_valid_o/out_stall_i | data_byte_o, packet_kind_o,
//         |           |                       | byte_index_o, packet_end_o, dropped_o
// cfg     | in        | cfg_we_i              | cfg_data_i (vendor packet length)
//
// One byte per cycle while rx_stall_o is low; each result is registered in the
// output entry, or in the skid entry while out is stalled. The parser state
// updates in the accept cycle. The skid entry holds one result; rx_stall_o rises
// only when both entries are full. Reset returns the parser to idle and empties
// both entries; vendor length resets to ten.
`default_nettype none

module hci_uart_packet_deframer
  import hud_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ByteW-1:0]  cfg_data_i,
  input  wire logic              rx_valid_i,
  output      logic              rx_stall_o,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [ByteW-1:0]  data_byte_o,
  output      logic [1:0]        packet_kind_o,
  output      logic [CountW-1:0] byte_index_o,
  output      logic              packet_end_o,
  output      logic              dropped_o
);

  logic [ByteW-1:0]  vendor_len_q;
  parse_state_e      state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              known_q, known_d;
  logic [CountW-1:0] total_q, total_d;
  logic [ByteW-1:0]  acl_low_q, acl_low_d;

  result_t           res_d, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              accept, out_fire;
  logic [CountW-1:0] count_inc;

  assign rx_stall_o = skid_valid_q;
  assign accept     = rx_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign count_inc  = count_q + CountW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    known_d   = known_q;
    total_d   = total_q;
    acl_low_d = acl_low_q;
    res_d.data_byte   = rx_byte_i;
    res_d.packet_kind = KindNone;
    res_d.byte_index  = '0;
    res_d.packet_end  = 1'b0;
    res_d.dropped     = 1'b0;
    case (state_q)
      StEvent, StAcl, StVendor: begin
        res_d.byte_index = count_q;
        count_d = count_inc;
        case (state_q)
          StEvent: begin
            res_d.packet_kind = KindEvent;
            if (count_inc == EventLenPos) begin
              total_d = CountW'(rx_byte_i) + EventOvh;
              known_d = 1'b1;
            end
          end
          StAcl: begin
            res_d.packet_kind = KindAcl;
            if (count_inc == AclLowPos) acl_low_d = rx_byte_i;
            if (count_inc == AclHighPos) begin
              total_d = CountW'({rx_byte_i, acl_low_q}) + AclOvh;
              known_d = 1'b1;
            end
          end
          default: res_d.packet_kind = KindVendor;
        endcase
        if (known_d && count_d == total_d) begin
          res_d.packet_end = 1'b1;
          state_d = StIdle;
          count_d = '0;
          known_d = 1'b0;
        end
      end
      default: begin
        count_d = CountW'(1);
        known_d = 1'b0;
        total_d = '0;
        if (rx_byte_i == HdrEvent) begin
          res_d.packet_kind = KindEvent;
          state_d = StEvent;
        end else if (rx_byte_i == HdrAcl) begin
          res_d.packet_kind = KindAcl;
          state_d = StAcl;
        end else if (rx_byte_i == HdrVendor) begin
          res_d.packet_kind = KindVendor;
          state_d = StVendor;
          total_d = (vendor_len_q < VendorLenMin) ? CountW'(VendorLenMin)
                                                  : CountW'(vendor_len_q);
          known_d = 1'b1;
        end else begin
          state_d = StIdle;
          count_d = '0;
          res_d.dropped = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_len_q <= VendorLenReset;
    end else if (cfg_we_i) begin
      vendor_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      known_q   <= 1'b0;
      total_q   <= '0;
      acl_low_q <= '0;
    end else if (accept) begin
      state_q   <= state_d;
      count_q   <= count_d;
      known_q   <= known_d;
      total_q   <= total_d;
      acl_low_q <= acl_low_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = out_q.data_byte;
  assign packet_kind_o = out_q.packet_kind;
  assign byte_index_o  = out_q.byte_index;
  assign packet_end_o  = out_q.packet_end;
  assign dropped_o     = out_q.dropped;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output entry empty");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |->
      (packet_kind_o == KindNone && byte_index_o == '0 && !packet_end_o))
    else $error("dropped beat carries packet fields");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_d.packet_end) |=> (state_q == StIdle && count_q == '0))
    else $error("parser not idle after packet end");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!known_q && count_q == '0))
    else $error("idle parser holds stale length state");

endmodule

`default_nettype wire

// File: bench/hud_deframe_checker.sv
// Checker for the HCI UART packet deframer: tracks packet framing for every
// accepted rx beat, queues the expected out beats and compares them.
// Depends on hud_pkg.
module hud_deframe_checker
  import hud_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ByteW-1:0]  cfg_data_i,
  input  wire logic              rx_valid_i,
  input  wire logic              rx_stall_i,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic [1:0]        packet_kind_i,
  input  wire logic [CountW-1:0] byte_index_i,
  input  wire logic              packet_end_i,
  input  wire logic              dropped_i,
  output int unsigned            fail_count_o,
  output int unsigned            results_pending_o,
  output logic                   parser_busy_o
);

  localparam int unsigned MaxReports = 10;

  result_t           expected_results[$];
  logic [ByteW-1:0]  vendor_len;
  parse_state_e      frame_state;
  logic [CountW-1:0] frame_count;
  logic [CountW-1:0] frame_total;
  logic              frame_total_known;
  logic [ByteW-1:0]  acl_len_low;
  int unsigned       fails;

  function automatic result_t deframe_byte(input logic [ByteW-1:0] rx);
    result_t res;
    res.data_byte   = rx;
    res.packet_kind = KindNone;
    res.byte_index  = '0;
    res.packet_end  = 1'b0;
    res.dropped     = 1'b0;
    if (frame_state == StIdle) begin
      frame_count       = CountW'(1);
      frame_total_known = 1'b0;
      frame_total       = '0;
      case (rx)
        HdrEvent: begin
          res.packet_kind = KindEvent;
          frame_state     = StEvent;
        end
        HdrAcl: begin
          res.packet_kind = KindAcl;
          frame_state     = StAcl;
        end
        HdrVendor: begin
          res.packet_kind   = KindVendor;
          frame_state       = StVendor;
          frame_total       = (vendor_len < VendorLenMin) ? CountW'(VendorLenMin)
                                                          : CountW'(vendor_len);
          frame_total_known = 1'b1;
        end
        default: begin
          frame_count = '0;
          res.dropped = 1'b1;
        end
      endcase
    end else begin
      res.byte_index = frame_count;
      frame_count    = frame_count + CountW'(1);
      case (frame_state)
        StEvent: begin
          res.packet_kind = KindEvent;
          if (frame_count == EventLenPos) begin
            frame_total       = CountW'(rx) + EventOvh;
            frame_total_known = 1'b1;
          end
        end
        StAcl: begin
          res.packet_kind = KindAcl;
          if (frame_count == AclLowPos) acl_len_low = rx;
          if (frame_count == AclHighPos) begin
            frame_total       = CountW'({rx, acl_len_low}) + AclOvh;
            frame_total_known = 1'b1;
          end
        end
        default: res.packet_kind = KindVendor;
      endcase
      if (frame_total_known && frame_count == frame_total) begin
        res.packet_end    = 1'b1;
        frame_state       = StIdle;
        frame_count       = '0;
        frame_total_known = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      vendor_len        = VendorLenReset;
      frame_state       = StIdle;
      frame_count       = '0;
      frame_total       = '0;
      frame_total_known = 1'b0;
      acl_len_low       = '0;
      fails             = 0;
      fail_count_o      <= 0;
      results_pending_o <= 0;
      parser_busy_o     <= 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= MaxReports)
            $display("unexpected beat: byte %02h kind %0d index %0d end %0b drop %0b",
                     data_byte_i, packet_kind_i, byte_index_i, packet_end_i, dropped_i);
        end else begin
          want = expected_results.pop_front();
          if (data_byte_i !== want.data_byte || packet_kind_i !== want.packet_kind ||
              byte_index_i !== want.byte_index || packet_end_i !== want.packet_end ||
              dropped_i !== want.dropped) begin
            fails++;
            if (fails <= MaxReports)
              $display({"mismatch: expected byte %02h kind %0d index %0d end %0b drop %0b,",
                        " got byte %02h kind %0d index %0d end %0b drop %0b"},
                       want.data_byte, want.packet_kind, want.byte_index, want.packet_end,
                       want.dropped, data_byte_i, packet_kind_i, byte_index_i,
                       packet_end_i, dropped_i);
          end
        end
      end
      if (rx_valid_i && !rx_stall_i) expected_results.push_back(deframe_byte(rx_byte_i));
      if (cfg_we_i) vendor_len = cfg_data_i;
      fail_count_o      <= fails;
      results_pending_o <= expected_results.size();
      parser_busy_o     <= (frame_state != StIdle);
    end
  end

endmodule

// File: bench/hci_uart_packet_deframer_tb.sv
// Testbench top for the HCI UART packet deframer: clock, reset, byte stream
// stimulus, output stall pattern and the final verdict.
// Depends on hud_pkg, hud_deframe_checker and the deframer RTL.
module hci_uart_packet_deframer_tb;
  import hud_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned RandomBytes = 330;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [ByteW-1:0]  cfg_data_i  = '0;
  logic              rx_valid_i  = 1'b0;
  logic [ByteW-1:0]  rx_byte_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              rx_stall_o;
  logic              out_valid_o;
  logic [ByteW-1:0]  data_byte_o;
  logic [1:0]        packet_kind_o;
  logic [CountW-1:0] byte_index_o;
  logic              packet_end_o;
  logic              dropped_o;

  int unsigned fail_count;
  int unsigned results_pending;
  logic        parser_busy;

  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  stall_mode_e stall_mode     = StallNone;
  int unsigned burst_left     = 0;
  int unsigned bytes_sent     = 0;
  int unsigned vendor_len_now = 32'(VendorLenReset);

  hci_uart_packet_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .packet_kind_o (packet_kind_o),
    .byte_index_o  (byte_index_o),
    .packet_end_o  (packet_end_o),
    .dropped_o     (dropped_o)
  );

  hud_deframe_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .rx_valid_i        (rx_valid_i),
    .rx_stall_i        (rx_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .data_byte_i       (data_byte_o),
    .packet_kind_i     (packet_kind_o),
    .byte_index_i      (byte_index_o),
    .packet_end_i      (packet_end_o),
    .dropped_i         (dropped_o),
    .fail_count_o      (fail_count),
    .results_pending_o (results_pending),
    .parser_busy_o     (parser_busy)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(40, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= ((stall_left % 5) < 2);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] value);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
    end
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (rx_stall_o);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic write_vendor_len(input logic [ByteW-1:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    vendor_len_now = 32'(value);
  endtask

  task automatic send_event(input logic [ByteW-1:0] len);
    send_byte(HdrEvent);
    send_byte(rand_byte());
    send_byte(len);
    repeat (len) send_byte(rand_byte());
  endtask

  task automatic send_acl(input logic [15:0] len);
    send_byte(HdrAcl);
    send_byte(rand_byte());
    send_byte(rand_byte());
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (len) send_byte(rand_byte());
  endtask

  task automatic send_vendor();
    send_byte(HdrVendor);
    repeat (((vendor_len_now < VendorLenMin) ? VendorLenMin : vendor_len_now) - 1)
      send_byte(rand_byte());
  endtask

  // pad with short length bytes until the parser is back at idle
  task automatic finish_packet();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (parser_busy) begin
      send_byte(ByteW'($urandom_range(0, 1)));
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned      random_goal;
    int unsigned      pick;
    logic [ByteW-1:0] noise;
    logic [ByteW-1:0] new_len;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h03);
    send_event(8'd0);
    send_acl(16'd0);
    send_vendor();
    send_event(8'd1);
    send_acl(16'd1);

    write_vendor_len(8'd0);
    send_vendor();
    write_vendor_len(8'd1);
    send_vendor();
    write_vendor_len(8'd255);
    send_vendor();
    write_vendor_len(8'd3);
    send_byte(HdrVendor);
    send_byte(rand_byte());
    write_vendor_len(8'd9);
    send_byte(rand_byte());
    send_vendor();
    write_vendor_len(8'd2);
    send_vendor();

    send_event(8'd255);
    send_acl(16'h0100);

    random_goal = bytes_sent + RandomBytes;
    while (bytes_sent < random_goal) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 9))
          0:       new_len = 8'd0;
          1:       new_len = 8'd1;
          2:       new_len = 8'd255;
          default: new_len = ByteW'($urandom_range(2, 16));
        endcase
        write_vendor_len(new_len);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_event(($urandom_range(0, 15) == 0) ? rand_byte()
                                                : ByteW'($urandom_range(0, 12)));
      end else if (pick < 60) begin
        send_acl(($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 400))
                                              : 16'($urandom_range(0, 12)));
      end else if (pick < 78) begin
        send_vendor();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          do noise = rand_byte();
          while (noise == HdrEvent || noise == HdrAcl || noise == HdrVendor);
          send_byte(noise);
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       send_byte(HdrEvent);
          1:       send_byte(HdrAcl);
          default: send_byte(HdrVendor);
        endcase
        repeat ($urandom_range(0, 3)) send_byte(rand_byte());
        finish_packet();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && results_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
